>>> sv/mrpd_pkg.sv
// Shared types, constants and register codes of the motor ramp and PWM drive.
`timescale 1ns / 1ps

package mrpd_pkg;

   localparam int Motors      = 4;
   localparam int SpeedW      = 8;
   localparam int StepW       = 7;
   localparam int LimitW      = 7;
   localparam int DutyW       = 8;
   localparam int TicksW      = 2;
   localparam int CsrIndexW   = 3;
   localparam int CsrDataW    = 7;
   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCountW = $clog2(QueueDepth + 1);

   // command codes of an input word
   localparam logic CmdSpeed = 1'b0;
   localparam logic CmdTick  = 1'b1;

   // duty = mag*255/100 done as one multiply by a scaled reciprocal
   localparam int          ScaleShift = 22;
   localparam int          Recip100   = ((2 ** ScaleShift) + 99) / 100;
   localparam int          DutyMulW   = 24;
   localparam int          ScaledW    = 9;
   localparam int          ProdW      = LimitW + DutyMulW;
   localparam logic [DutyMulW-1:0] DutyMul = DutyMulW'(255 * Recip100);
   localparam logic [DutyW-1:0]    DutyFull = '1;

   typedef logic signed [SpeedW-1:0] speed_type;
   typedef logic [Motors-1:0][SpeedW-1:0] speed_vec_type;

   typedef enum logic [CsrIndexW-1:0] {
      REG_RAMP_MODE    = 3'd0,
      REG_RAMP_STEP    = 3'd1,
      REG_SPEED_LIMIT  = 3'd2,
      REG_REVERSE_MASK = 3'd3,
      REG_ALT_PWM_MASK = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic              ramp_mode;
      logic [StepW-1:0]  ramp_step;
      logic [LimitW-1:0] speed_limit;
      logic [Motors-1:0] reverse_mask;
      logic [Motors-1:0] alt_pwm_mask;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      ramp_mode:    1'b0,
      ramp_step:    7'd3,
      speed_limit:  7'd100,
      reverse_mask: 4'd0,
      alt_pwm_mask: 4'd0
   };

   typedef struct packed {
      logic      cmd;
      speed_type target_a;
      speed_type target_b;
      speed_type target_c;
      speed_type target_d;
   } req_type;

   typedef struct packed {
      logic [DutyW-1:0] duty_a;
      logic [DutyW-1:0] duty_b;
      logic [DutyW-1:0] duty_c;
      logic [DutyW-1:0] duty_d;
      logic             reverse_a;
      logic             reverse_b;
      logic             reverse_c;
      logic             reverse_d;
   } rsp_type;

   // one set of speeds to drive, between front end, queue and back end
   typedef struct packed {
      logic          valid;
      speed_vec_type speeds;
   } drive_req_type;

endpackage

>>> sv/mrpd_front.sv
// Front end: takes words, counts ticks and runs the speed ramp.
`timescale 1ns / 1ps

module mrpd_front
   import mrpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_push,
   input  req_type       req_word,
   input  logic          q_full,
   output drive_req_type push_req
);

   speed_vec_type     cur_ff, cur_in;
   logic [TicksW-1:0] ticks_ff, ticks_in;
   speed_vec_type     tgt, stepped;
   logic              accept, step_now;

   function automatic speed_type ramp_one(input speed_type cur, input speed_type tgt_v,
                                          input logic [StepW-1:0] step);
      logic signed [SpeedW:0] diff;
      logic [SpeedW:0]        mag;
      logic signed [SpeedW:0] step9;
      logic signed [SpeedW:0] res;
      diff  = {tgt_v[SpeedW-1], tgt_v} - {cur[SpeedW-1], cur};
      mag   = diff[SpeedW] ? (SpeedW+1)'(-diff) : diff;
      step9 = $signed({{(SpeedW+1-StepW){1'b0}}, step});
      if (mag < {{(SpeedW+1-StepW){1'b0}}, step}) begin
         res = {tgt_v[SpeedW-1], tgt_v};
      end else if (diff > 0) begin
         res = {cur[SpeedW-1], cur} + step9;
      end else if (diff < 0) begin
         res = {cur[SpeedW-1], cur} - step9;
      end else begin
         res = {cur[SpeedW-1], cur};
      end
      return res[SpeedW-1:0];
   endfunction

   assign tgt[0] = req_word.target_a;
   assign tgt[1] = req_word.target_b;
   assign tgt[2] = req_word.target_c;
   assign tgt[3] = req_word.target_d;

   assign accept   = req_push && !q_full;
   assign step_now = !req_word.cmd && cfg.ramp_mode && (ticks_ff >= TicksW'(2));

   always_comb begin
      for (int i = 0; i < Motors; i++) begin
         stepped[i] = ramp_one(cur_ff[i], tgt[i], cfg.ramp_step);
      end
   end

   always_comb begin
      push_req.valid  = accept && !req_word.cmd;
      push_req.speeds = cfg.ramp_mode ? (step_now ? stepped : cur_ff) : tgt;
   end

   always_comb begin
      cur_in   = cur_ff;
      ticks_in = ticks_ff;
      if (accept) begin
         if (req_word.cmd) begin
            if (ticks_ff != '1) ticks_in = ticks_ff + TicksW'(1);
         end else if (step_now) begin
            cur_in   = stepped;
            ticks_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         ticks_ff <= '0;
      end else begin
         cur_ff   <= cur_in;
         ticks_ff <= ticks_in;
      end
   end

endmodule

>>> sv/mrpd_queue.sv
// Short queue of drive words between front end and back end.
`timescale 1ns / 1ps

module mrpd_queue
   import mrpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  drive_req_type push_req,
   output logic          full,
   output drive_req_type head,
   input  logic          pop
);

   speed_vec_type          entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountW-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   function automatic logic [QueuePtrW-1:0] ptr_next(input logic [QueuePtrW-1:0] p);
      return (p == QueuePtrW'(QueueDepth - 1)) ? '0 : p + QueuePtrW'(1);
   endfunction

   assign full        = (count_ff == QueueCountW'(QueueDepth));
   assign head.valid  = (count_ff != '0);
   assign head.speeds = entries_ff[rd_ptr_ff];

   assign do_push = push_req.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QueueCountW'(1);
      if (do_pop && !do_push) count_in = count_ff - QueueCountW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) entries_ff[wr_ptr_ff] <= push_req.speeds;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/mrpd_back.sv
// Back end: reverse and clamp stage, then duty stage and result register.
`timescale 1ns / 1ps

module mrpd_back
   import mrpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  drive_req_type head,
   output logic          q_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_word
);

   typedef struct packed {
      logic              neg;
      logic              alt;
      logic [LimitW-1:0] mag;
   } lane_type;

   typedef lane_type [Motors-1:0] lane_vec_type;

   lane_vec_type      lanes;
   lane_vec_type      s1_lanes_ff;
   logic              s1_valid_ff, s1_valid_in;
   rsp_type           rsp_word_ff, rsp_word_in;
   logic              s2_valid_ff, s2_valid_in;
   logic              s1_take, s2_advance, s2_drain;
   logic [DutyW-1:0]  duty [Motors];
   logic [Motors-1:0] dir;

   function automatic lane_type clamp_lane(input speed_type spd, input logic rev,
                                           input logic alt, input logic [LimitW-1:0] lim);
      logic signed [SpeedW:0] s9;
      logic signed [SpeedW:0] lim9;
      logic [SpeedW:0]        mag9;
      lane_type               l;
      s9   = {spd[SpeedW-1], spd};
      if (rev) s9 = -s9;
      lim9 = $signed({{(SpeedW+1-LimitW){1'b0}}, lim});
      if (s9 > lim9) begin
         s9 = lim9;
      end else if (s9 < -lim9) begin
         s9 = -lim9;
      end
      mag9  = s9[SpeedW] ? (SpeedW+1)'(-s9) : s9;
      l.neg = s9[SpeedW];
      l.alt = alt;
      l.mag = mag9[LimitW-1:0];
      return l;
   endfunction

   function automatic logic [DutyW-1:0] duty_of(input lane_type l);
      logic [ProdW-1:0]   prod;
      logic [ScaledW-1:0] scaled;
      logic               sat;
      logic [DutyW-1:0]   d;
      prod   = ProdW'(l.mag) * ProdW'(DutyMul);
      scaled = prod[ScaleShift +: ScaledW];
      sat    = scaled[ScaledW-1];
      if (!l.neg || l.alt) begin
         d = sat ? DutyFull : scaled[DutyW-1:0];
      end else begin
         d = sat ? '0 : DutyFull - scaled[DutyW-1:0];
      end
      return d;
   endfunction

   // handshakes of the two stages
   assign s2_drain   = s2_valid_ff && rsp_pop;
   assign s2_advance = s1_valid_ff && (!s2_valid_ff || rsp_pop);
   assign s1_take    = !s1_valid_ff || s2_advance;
   assign q_pop      = head.valid && s1_take;

   always_comb begin
      for (int i = 0; i < Motors; i++) begin
         lanes[i] = clamp_lane(head.speeds[i], cfg.reverse_mask[i],
                               cfg.alt_pwm_mask[i], cfg.speed_limit);
      end
   end

   always_comb begin
      for (int i = 0; i < Motors; i++) begin
         duty[i] = duty_of(s1_lanes_ff[i]);
         dir[i]  = s1_lanes_ff[i].neg;
      end
   end

   always_comb begin
      rsp_word_in.duty_a    = duty[0];
      rsp_word_in.duty_b    = duty[1];
      rsp_word_in.duty_c    = duty[2];
      rsp_word_in.duty_d    = duty[3];
      rsp_word_in.reverse_a = dir[0];
      rsp_word_in.reverse_b = dir[1];
      rsp_word_in.reverse_c = dir[2];
      rsp_word_in.reverse_d = dir[3];
   end

   always_comb begin
      s1_valid_in = q_pop ? 1'b1 : (s2_advance ? 1'b0 : s1_valid_ff);
      s2_valid_in = s2_advance ? 1'b1 : (s2_drain ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (q_pop) s1_lanes_ff <= lanes;
      if (s2_advance) rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign rsp_empty = !s2_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

>>> sv/motor_ramp_pwm_drive.sv
// Top level of the four-motor speed ramp and PWM drive.
`timescale 1ns / 1ps

// Takes one word per clock while req_full is low: a tick word (cmd 1)
// bumps the millisecond count and gives no result; a speed word (cmd 0)
// gives exactly one result word of four duties and four direction bits.
// Results come out in order: a taken speed word's entry is written into
// the queue, then moved into the reverse/clamp stage and then into the
// duty stage, whose register drives rsp_word. req_full rises only when
// the result side has stopped popping and four results are held inside
// (queue plus both back-end stages); a steady pop keeps one word per cycle
// flowing. Ramp state and the tick count live in the front end and update
// as each word is taken, so the back end may lag without affecting them.
// Duty is |s|*255/100 truncated (one constant multiply per motor), or
// 255 minus that for negative speeds on motors whose alt bit is clear;
// it saturates when the speed limit is above 100. Configuration writes take
// effect at once and are meant to happen while no speed word is in flight.
// Register indexes: 0 ramp_mode, 1 ramp_step, 2 speed limit, 3 reverse_mask,
// 4 alt_pwm_mask; writes to other indexes are dropped.

module motor_ramp_pwm_drive
   import mrpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_word,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_word,
   input  logic                 csr_write_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   drive_req_type push_req;
   drive_req_type head;
   logic          q_full;
   logic          q_pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_RAMP_MODE:    cfg_in.ramp_mode    = csr_wdata[0];
            REG_RAMP_STEP:    cfg_in.ramp_step    = csr_wdata[StepW-1:0];
            REG_SPEED_LIMIT:  cfg_in.speed_limit  = csr_wdata[LimitW-1:0];
            REG_REVERSE_MASK: cfg_in.reverse_mask = csr_wdata[Motors-1:0];
            REG_ALT_PWM_MASK: cfg_in.alt_pwm_mask = csr_wdata[Motors-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: tick count and ramp
   mrpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_word (req_word),
      .q_full   (q_full),
      .push_req (push_req)
   );

   // decouples ramp from drive stages
   mrpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_req (push_req),
      .full     (q_full),
      .head     (head),
      .pop      (q_pop)
   );

   // back end: clamp, duty, result register
   mrpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   assign req_full = q_full;

endmodule

>>> sv/mrpd_checker.sv
// Port-level checks on the motor ramp and PWM drive, bound to the top level.
`timescale 1ns / 1ps

module mrpd_checker
   import mrpd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_word
);

   // reset leaves nothing queued and nothing waiting
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not empty after reset");

   // queue can only be full when both back-end stages hold words; checked as a result waiting
   a_full_means_result: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input full with no result waiting");

   // a result word leaves only when popped
   a_empty_by_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop) || $past(reset))
      else $error("result lost without pop");

   // queue fills only through a push
   a_full_by_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("full rose without push");

   // a waiting result holds until popped
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
      else $error("waiting result changed");

endmodule

bind motor_ramp_pwm_drive mrpd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);
